/* sv/tea_pkg.sv */
`default_nettype none
package tea_pkg;

  localparam int unsigned WORD_W = 32;
  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e3779b9;
  localparam int unsigned CFG_INDEX_W = 2;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KEY_WORD0 = 2'd0,
    REG_KEY_WORD1 = 2'd1,
    REG_KEY_WORD2 = 2'd2,
    REG_KEY_WORD3 = 2'd3
  } cfg_reg_t;

  // One slot of the round pipeline.
  typedef struct packed {
    logic  valid;
    word_t w0;
    word_t w1;
  } stage_t;

  function automatic word_t tea_mix(input word_t w, input word_t sum,
                                    input word_t ka, input word_t kb);
    return ((w << 4) + ka) ^ (w + sum) ^ ((w >> 5) + kb);
  endfunction

endpackage
`default_nettype wire

/* sv/tea_plain_if.sv */
`default_nettype none
interface tea_plain_if
  import tea_pkg::*;
();
  logic  valid;
  logic  ready;
  word_t plain_low;
  word_t plain_high;

  modport source (output valid, output plain_low, output plain_high, input ready);
  modport sink (input valid, input plain_low, input plain_high, output ready);
endinterface
`default_nettype wire

/* sv/tea_cipher_if.sv */
`default_nettype none
interface tea_cipher_if
  import tea_pkg::*;
();
  logic  valid;
  logic  ready;
  word_t cipher_low;
  word_t cipher_high;

  modport source (output valid, output cipher_low, output cipher_high, input ready);
  modport sink (input valid, input cipher_low, input cipher_high, output ready);
endinterface
`default_nettype wire

/* sv/tea_cfg_if.sv */
`default_nettype none
interface tea_cfg_if
  import tea_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  word_t                  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* sv/tea_block_encrypt_top.sv */
// TEA block encryption, one half-round per pipeline cell, 2*ROUND_COUNT cells.
// Each block is registered in every cell, then written to the output queue.
// Throughput: one block per cycle; the chain stalls only when both output
// queue entries are held by a stalled consumer.
// Reset (synchronous, rst high) empties the pipeline and queue and clears
// all four key words to zero.
`default_nettype none
module tea_block_encrypt_top
  import tea_pkg::*;
#(
  parameter int unsigned ROUND_COUNT = 32
) (
  input  wire          clk,
  input  wire          rst,
  tea_cfg_if.sink      cfg,
  tea_plain_if.sink    blk_in,
  tea_cipher_if.source blk_out
);

  localparam int unsigned CELLS = 2 * ROUND_COUNT;

  word_t  key [4];
  stage_t stg [CELLS+1];
  logic   en;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key[0] <= '0;
      key[1] <= '0;
      key[2] <= '0;
      key[3] <= '0;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_KEY_WORD0: key[0] <= cfg.data;
        REG_KEY_WORD1: key[1] <= cfg.data;
        REG_KEY_WORD2: key[2] <= cfg.data;
        REG_KEY_WORD3: key[3] <= cfg.data;
        default: ;
      endcase
    end
  end

  assign blk_in.ready = en;
  assign stg[0] = '{valid: blk_in.valid, w0: blk_in.plain_low, w1: blk_in.plain_high};

  for (genvar c = 0; c < CELLS; c++) begin : g_cell
    tea_cell #(
      .ROUND (c / 2),
      .HALF  ((c % 2) == 1)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .ka   (key[2*(c%2)]),
      .kb   (key[2*(c%2)+1]),
      .prev (stg[c]),
      .cur  (stg[c+1])
    );
  end

  tea_out_buf u_out_buf (
    .clk  (clk),
    .rst  (rst),
    .last (stg[CELLS]),
    .en   (en),
    .out  (blk_out)
  );

endmodule
`default_nettype wire

/* sv/tea_cell.sv */
`default_nettype none
// One half-round of TEA. The first half of a round updates word0 from word1,
// the second half updates word1 from the new word0.
module tea_cell
  import tea_pkg::*;
#(
  parameter int unsigned ROUND = 0,
  parameter bit          HALF  = 1'b0
) (
  input  wire    clk,
  input  wire    rst,
  input  wire    en,
  input  word_t  ka,
  input  word_t  kb,
  input  stage_t prev,
  output stage_t cur
);

  localparam logic [2*WORD_W-1:0] SUM_FULL = (2*WORD_W)'(TEA_DELTA) * (2*WORD_W)'(ROUND + 1);
  localparam word_t SUM = SUM_FULL[WORD_W-1:0];

  stage_t cur_next;

  always_comb begin
    cur_next = prev;
    if (HALF == 1'b0) begin
      cur_next.w0 = prev.w0 + tea_mix(prev.w1, SUM, ka, kb);
    end else begin
      cur_next.w1 = prev.w1 + tea_mix(prev.w0, SUM, ka, kb);
    end
  end

  // Only the valid bit is reset; the data words follow it.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (en) begin
      cur.valid <= cur_next.valid;
    end
    if (en) begin
      cur.w0 <= cur_next.w0;
      cur.w1 <= cur_next.w1;
    end
  end

endmodule
`default_nettype wire

/* sv/tea_out_buf.sv */
`default_nettype none
// Two-entry output queue. The pipeline moves only while a slot is free, so
// the upstream ready never depends on the downstream ready in the same cycle.
module tea_out_buf
  import tea_pkg::*;
(
  input  wire          clk,
  input  wire          rst,
  input  stage_t       last,
  output logic         en,
  tea_cipher_if.source out
);

  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  word_t      mem_w0 [2];
  word_t      mem_w1 [2];
  logic       push;
  logic       pop;

  assign en   = (count != 2'd2);
  assign push = en && last.valid;
  assign pop  = out.valid && out.ready;

  assign out.valid       = (count != 2'd0);
  assign out.cipher_low  = mem_w0[rd_ptr];
  assign out.cipher_high = mem_w1[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_w0[wr_ptr] <= last.w0;
      mem_w1[wr_ptr] <= last.w1;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("output queue count out of range");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2) |-> !push)
    else $error("push into full output queue");

  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !pop) |=> (count == 2'd2))
    else $error("full output queue lost an entry without a transfer");

endmodule
`default_nettype wire

/* sim/tb_tea_block_encrypt_top.sv */
`timescale 1ns / 100ps
module tb_tea_block_encrypt_top;
  import tea_pkg::*;

  localparam int ROUNDS = 32;
  localparam int PIPE_DEPTH = 2 * ROUNDS + 1;
  localparam int PHASE_COUNT = 8;
  localparam int PHASE_BLOCKS = 213;

  typedef struct packed {
    word_t low;
    word_t high;
  } cipher_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tea_cfg_if    cfg_ch ();
  tea_plain_if  plain_ch ();
  tea_cipher_if cipher_ch ();

  tea_block_encrypt_top #(
    .ROUND_COUNT(ROUNDS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .blk_in (plain_ch),
    .blk_out(cipher_ch)
  );

  always #1 clk = ~clk;

  word_t   key_words [4];
  cipher_t pending_cipher [$];
  int      fail_count = 0;
  bit      idle_enable = 1'b1;

  // The key words in the model start at their reset value of zero.
  initial begin
    key_words = '{default: '0};
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    plain_ch.valid = 1'b0;
    plain_ch.plain_low = '0;
    plain_ch.plain_high = '0;
    cipher_ch.ready = 1'b0;
  end

  // Model of the cipher under the current key words.
  function automatic cipher_t tea_encrypt_block(input word_t lo, input word_t hi);
    word_t   v0;
    word_t   v1;
    word_t   sum;
    cipher_t blk;
    v0 = lo;
    v1 = hi;
    sum = '0;
    for (int r = 0; r < ROUNDS; r++) begin
      sum = sum + TEA_DELTA;
      v0 = v0 + ((((v1 << 4) + key_words[REG_KEY_WORD0]) ^ (v1 + sum)) ^
                 ((v1 >> 5) + key_words[REG_KEY_WORD1]));
      v1 = v1 + ((((v0 << 4) + key_words[REG_KEY_WORD2]) ^ (v0 + sum)) ^
                 ((v0 >> 5) + key_words[REG_KEY_WORD3]));
    end
    blk.low = v0;
    blk.high = v1;
    return blk;
  endfunction

  function automatic word_t rand_word();
    word_t w;
    case ($urandom_range(0, 9))
      0: w = '0;
      1: w = '1;
      2: w = word_t'(1) << $urandom_range(0, WORD_W - 1);
      3: w = ~(word_t'(1) << $urandom_range(0, WORD_W - 1));
      default: w = $urandom;
    endcase
    return w;
  endfunction

  task automatic write_key(input cfg_reg_t idx, input word_t val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    key_words[idx] = val;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic load_key(input word_t k0, input word_t k1, input word_t k2,
                          input word_t k3);
    write_key(REG_KEY_WORD0, k0);
    write_key(REG_KEY_WORD1, k1);
    write_key(REG_KEY_WORD2, k2);
    write_key(REG_KEY_WORD3, k3);
  endtask

  task automatic send_block(input word_t lo, input word_t hi);
    while (idle_enable && $urandom_range(0, 99) < 6) begin
      @(negedge clk);
      plain_ch.valid <= 1'b0;
    end
    @(negedge clk);
    plain_ch.valid <= 1'b1;
    plain_ch.plain_low <= lo;
    plain_ch.plain_high <= hi;
    do @(posedge clk); while (!plain_ch.ready);
    pending_cipher.push_back(tea_encrypt_block(lo, hi));
  endtask

  // Drop valid and hold off until every outstanding block has come back.
  task automatic drain_pipeline();
    @(negedge clk);
    plain_ch.valid <= 1'b0;
    while (pending_cipher.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    cipher_ch.ready <= !(idle_enable && $urandom_range(0, 99) < 6);
  end

  always @(posedge clk) begin : cipher_check
    cipher_t exp_blk;
    if (!rst && cipher_ch.valid && cipher_ch.ready) begin
      if (pending_cipher.size() == 0) begin
        $error("unexpected result transfer: cipher_low=%h cipher_high=%h",
               cipher_ch.cipher_low, cipher_ch.cipher_high);
        fail_count++;
      end else begin
        exp_blk = pending_cipher.pop_front();
        if (cipher_ch.cipher_low !== exp_blk.low) begin
          $error("cipher_low: expected %h, got %h", exp_blk.low, cipher_ch.cipher_low);
          fail_count++;
        end
        if (cipher_ch.cipher_high !== exp_blk.high) begin
          $error("cipher_high: expected %h, got %h", exp_blk.high, cipher_ch.cipher_high);
          fail_count++;
        end
      end
    end
  end

  // The key words come out of reset as zero.
  task automatic test_reset_key();
    send_block(32'h0000_0000, 32'h0000_0000);
    send_block(32'hffff_ffff, 32'hffff_ffff);
    send_block(32'h0000_0000, 32'hffff_ffff);
    send_block(32'hffff_ffff, 32'h0000_0000);
    send_block(32'h8000_0000, 32'h0000_0001);
    send_block(32'h0000_0001, 32'h8000_0000);
    drain_pipeline();
  endtask

  task automatic test_key_extremes();
    load_key('1, '1, '1, '1);
    send_block(32'h0000_0000, 32'h0000_0000);
    send_block(32'hffff_ffff, 32'hffff_ffff);
    send_block(32'h7fff_ffff, 32'h8000_0000);
    send_block(32'haaaa_aaaa, 32'h5555_5555);
    drain_pipeline();
    load_key(32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h0000_0001);
    send_block(32'h5555_5555, 32'haaaa_aaaa);
    send_block(32'h0000_0001, 32'hffff_fffe);
    send_block(32'hffff_ffff, 32'h0000_0000);
    send_block(32'h0123_4567, 32'h89ab_cdef);
    drain_pipeline();
    load_key(32'h5555_5555, 32'haaaa_aaaa, 32'h7fff_ffff, 32'hfedc_ba98);
    send_block(32'h0000_0000, 32'h0000_0000);
    send_block(32'hffff_ffff, 32'hffff_ffff);
    drain_pipeline();
  endtask

  // Each phase loads a fresh key once the pipeline is empty; one phase runs
  // with neither side idling so the pipeline stays full end to end.
  task automatic test_random_traffic();
    word_t k [4];
    for (int p = 0; p < PHASE_COUNT; p++) begin
      for (int i = 0; i < 4; i++) k[i] = rand_word();
      if (p == PHASE_COUNT - 1) begin
        for (int i = 0; i < 4; i++) k[i] = '0;
      end
      load_key(k[0], k[1], k[2], k[3]);
      idle_enable = (p != 2);
      for (int n = 0; n < PHASE_BLOCKS; n++) begin
        send_block(rand_word(), rand_word());
      end
      drain_pipeline();
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_key();
    test_key_extremes();
    test_random_traffic();
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (fail_count == 0 && pending_cipher.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

endmodule
